// ===== sv/rcc_pkg.sv =====
// Package for the RC channel conditioner: field widths, pulse limits,
// hysteresis constants, channel codes and configuration register indexes.
// No dependencies.
package rcc_pkg;

  localparam int unsigned ChanW    = 3;
  localparam int unsigned PulseW   = 12;
  localparam int unsigned CmdW     = 13;
  localparam int unsigned DbW      = 9;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned Window   = 4;
  localparam int unsigned SlotW    = 2;

  localparam logic [PulseW-1:0] PulseMin = 12'd750;
  localparam logic [PulseW-1:0] PulseMax = 12'd2250;
  localparam logic [PulseW-1:0] MidReset = 12'd1500;

  // Arithmetic in the hysteresis and command path is done on 14-bit signed values.
  localparam logic signed [13:0] ThrottleCentre = 14'sd1500;
  localparam logic signed [13:0] HystLimit      = 14'sd3;
  localparam logic [PulseW-1:0]  HystStep       = 12'd2;
  localparam logic signed [13:0] CmdMax         = 14'sd4095;
  localparam logic signed [13:0] CmdMin         = -14'sd4096;

  typedef enum logic [ChanW-1:0] {
    ChRoll     = 3'd0,
    ChPitch    = 3'd1,
    ChYaw      = 3'd2,
    ChThrottle = 3'd3
  } chan_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgMidCommand   = 3'd0,
    CfgDeadbandRoll = 3'd1,
    CfgDeadbandPtch = 3'd2,
    CfgDeadbandYaw  = 3'd3
  } cfg_reg_e;

endpackage

// ===== sv/rc_channel_conditioner_unit.sv =====
// RC channel conditioner top level: input register, per-channel sample windows
// and held values, averaging, hysteresis and stick command logic, result register.
// Depends on rcc_pkg.
//
// Structure: input register, then all the work feeds the result register in a
// single pass. Throughput: one item per cycle while the result side takes items;
// the input register refills in the same cycle that its item moves into the
// result register, so a stalled result costs at most one buffered item. Reset
// (rst_ni low, asynchronous) clears all sample windows, slot pointers and held
// values to zero and loads the default config.
module rc_channel_conditioner_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] pulse_width, [15:12] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] channel
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] filtered_pulse, [24:12] stick_command,
                                      // [31:25] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] out_channel, [3] in_detent
  // Configuration writes.
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must see that they are written only while the block is idle.
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::PulseW-1:0] mid_q;
  logic [rcc_pkg::DbW-1:0]    db_roll_q, db_pitch_q, db_yaw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q      <= rcc_pkg::MidReset;
      db_roll_q  <= '0;
      db_pitch_q <= '0;
      db_yaw_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        rcc_pkg::CfgMidCommand:   mid_q      <= cfg_wdata_i;
        rcc_pkg::CfgDeadbandRoll: db_roll_q  <= cfg_wdata_i[rcc_pkg::DbW-1:0];
        rcc_pkg::CfgDeadbandPtch: db_pitch_q <= cfg_wdata_i[rcc_pkg::DbW-1:0];
        rcc_pkg::CfgDeadbandYaw:  db_yaw_q   <= cfg_wdata_i[rcc_pkg::DbW-1:0];
        default: ;  // indexes beyond the register list are ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. The result register advances when it is empty or being taken;
  // the input register accepts whenever it is empty or its item moves on.
  // ---------------------------------------------------------------------------
  logic                       in_valid_q, in_valid_d;
  logic [rcc_pkg::ChanW-1:0]  in_ch_q;
  logic [rcc_pkg::PulseW-1:0] in_pw_q;
  logic                       out_valid_q, out_valid_d;
  logic                       advance;
  logic                       in_accept;
  logic                       ch_ok;
  logic                       commit;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Items for channels that have no state are dropped without a result.
  assign ch_ok  = (32'(in_ch_q) < CHANNELS);
  assign commit = in_valid_q && ch_ok && advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = advance ? (in_valid_q && ch_ok) : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_ch_q <= s_axis_tuser;
      in_pw_q <= s_axis_tdata[rcc_pkg::PulseW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Per-channel state. State for the item in the input register is read here
  // and written back at the same edge that its result is registered, so an
  // item for the same channel in the next cycle already sees the update.
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::PulseW-1:0] win_q  [CHANNELS][rcc_pkg::Window];
  logic [rcc_pkg::SlotW-1:0]  slot_q [CHANNELS];
  logic [rcc_pkg::PulseW-1:0] held_q [CHANNELS];

  logic [ChIdxW-1:0]          ch_idx;
  logic [rcc_pkg::PulseW-1:0] sample;
  logic [rcc_pkg::SlotW-1:0]  slot_d;
  logic [rcc_pkg::PulseW-1:0] win_new [rcc_pkg::Window];
  logic [13:0]                sum;
  logic [rcc_pkg::PulseW-1:0] mean;
  logic [rcc_pkg::PulseW-1:0] held_old;
  logic [rcc_pkg::PulseW-1:0] held_d;
  logic signed [13:0]         mean_s, held_old_s;

  assign ch_idx = ChIdxW'(in_ch_q);

  // Out-of-range pulses are replaced by the centre value.
  assign sample = ((in_pw_q < rcc_pkg::PulseMin) || (in_pw_q > rcc_pkg::PulseMax)) ?
                  mid_q : in_pw_q;
  assign slot_d = slot_q[ch_idx] + 2'd1;

  always_comb begin
    sum = '0;
    for (int unsigned k = 0; k < rcc_pkg::Window; k++) begin
      win_new[k] = (slot_d == rcc_pkg::SlotW'(k)) ? sample : win_q[ch_idx][k];
      sum        = sum + 14'(win_new[k]);
    end
  end

  // Rounded mean of the four samples; the sum stays below 2^14 even after
  // the rounding term is added.
  logic [13:0] sum_rnd;
  assign sum_rnd = sum + 14'd2;
  assign mean    = sum_rnd[13:2];

  // Hysteresis: the held value moves only when the mean is more than three
  // counts away, and then settles two counts short of the mean.
  assign held_old   = held_q[ch_idx];
  assign mean_s     = $signed({2'b00, mean});
  assign held_old_s = $signed({2'b00, held_old});

  always_comb begin
    if (mean_s < held_old_s - rcc_pkg::HystLimit) begin
      held_d = mean + rcc_pkg::HystStep;
    end else if (mean_s > held_old_s + rcc_pkg::HystLimit) begin
      held_d = mean - rcc_pkg::HystStep;
    end else begin
      held_d = held_old;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned c = 0; c < CHANNELS; c++) begin
        slot_q[c] <= '0;
        held_q[c] <= '0;
        for (int unsigned k = 0; k < rcc_pkg::Window; k++) begin
          win_q[c][k] <= '0;
        end
      end
    end else if (commit) begin
      slot_q[ch_idx]          <= slot_d;
      held_q[ch_idx]          <= held_d;
      win_q[ch_idx][slot_d]   <= sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Stick command. Axes are centred and the deadband is cut out; throttle is
  // shifted by the centre's offset from nominal and saturated; aux gives zero.
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::DbW-1:0]    db;
  logic signed [13:0]         db_s, held_s, mid_s, centred, thr;
  logic signed [13:0]         cmd;
  logic                       detent;

  always_comb begin
    case (in_ch_q)
      rcc_pkg::ChRoll:  db = db_roll_q;
      rcc_pkg::ChPitch: db = db_pitch_q;
      rcc_pkg::ChYaw:   db = db_yaw_q;
      default:          db = '0;
    endcase
  end

  assign db_s    = $signed({5'b00000, db});
  assign held_s  = $signed({2'b00, held_d});
  assign mid_s   = $signed({2'b00, mid_q});
  assign centred = held_s - mid_s;
  assign thr     = centred + rcc_pkg::ThrottleCentre;

  always_comb begin
    cmd    = '0;
    detent = 1'b0;
    case (in_ch_q) inside
      rcc_pkg::ChRoll, rcc_pkg::ChPitch, rcc_pkg::ChYaw: begin
        if ((centred <= db_s) && (centred >= -db_s)) begin
          detent = 1'b1;
        end else if (centred > 14'sd0) begin
          cmd = centred - db_s;
        end else begin
          cmd = centred + db_s;
        end
      end
      rcc_pkg::ChThrottle: begin
        if (thr > rcc_pkg::CmdMax) begin
          cmd = rcc_pkg::CmdMax;
        end else if (thr < rcc_pkg::CmdMin) begin
          cmd = rcc_pkg::CmdMin;
        end else begin
          cmd = thr;
        end
      end
      default: ;  // aux channels report a zero command
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic [rcc_pkg::ChanW-1:0]  out_ch_q;
  logic [rcc_pkg::PulseW-1:0] out_filt_q;
  logic [rcc_pkg::CmdW-1:0]   out_cmd_q;
  logic                       out_detent_q;

  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_ch_q     <= in_ch_q;
      out_filt_q   <= held_d;
      out_cmd_q    <= cmd[rcc_pkg::CmdW-1:0];
      out_detent_q <= detent;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, out_cmd_q, out_filt_q};
  assign m_axis_tuser  = {out_detent_q, out_ch_q};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !s_axis_tready)
    else $error("input register would be overwritten while its item is blocked");

  a_no_foreign_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(out_ch_q) < CHANNELS))
    else $error("result presented for a channel without state");

  a_detent_zero_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_detent_q) |-> (out_cmd_q == '0))
    else $error("detent result with a nonzero command");

  a_detent_axis_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_detent_q) |->
      ((out_ch_q == rcc_pkg::ChRoll) || (out_ch_q == rcc_pkg::ChPitch) ||
       (out_ch_q == rcc_pkg::ChYaw)))
    else $error("detent flagged on a non-axis channel");

  a_result_follows_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> m_axis_tvalid)
    else $error("committed item did not produce a result");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for rc_channel_conditioner_unit: a tracker class keeps its own copy of
// the per-channel sample windows and held values and checks every result item in order.
// Depends on rcc_pkg and the conditioner RTL.
module tb;

  localparam int unsigned NumChannels = 8;
  // A run with no handshake on either side for this many cycles counts as hung.
  localparam int unsigned QuietLimit = 2000;
  // Cycles allowed after the last expected result before a config write or the verdict.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned ItemsPerPhase = 120;
  localparam int unsigned NumPhases = 8;
  localparam logic [rcc_pkg::ChanW-1:0] ChAuxFirst = 3'd4;
  // Register indexes above the yaw deadband are unused and must be ignored.
  localparam int unsigned FirstUnusedIndex = int'(rcc_pkg::CfgDeadbandYaw) + 1;

  // One result item as the block should present it.
  typedef struct {
    logic [rcc_pkg::ChanW-1:0]       out_channel;
    logic [rcc_pkg::PulseW-1:0]      filtered_pulse;
    logic signed [rcc_pkg::CmdW-1:0] stick_command;
    logic                            in_detent;
  } cond_result_t;

  // Tracks the conditioner state and holds the results still owed by the block.
  class channel_tracker;
    logic [rcc_pkg::PulseW-1:0] mid_cmd;
    logic [rcc_pkg::DbW-1:0]    deadband [3];
    logic [rcc_pkg::PulseW-1:0] window [NumChannels][rcc_pkg::Window];
    logic [rcc_pkg::SlotW-1:0]  slot [NumChannels];
    logic [rcc_pkg::PulseW-1:0] held_pulse [NumChannels];
    cond_result_t               pending_outputs [$];
    int unsigned                mismatches;

    function new();
      int c;
      int k;
      mid_cmd = rcc_pkg::MidReset;
      for (k = 0; k < 3; k++) deadband[k] = '0;
      for (c = 0; c < NumChannels; c++) begin
        slot[c] = '0;
        held_pulse[c] = '0;
        for (k = 0; k < rcc_pkg::Window; k++) window[c][k] = '0;
      end
      mismatches = 0;
    endfunction

    function void write_register(logic [rcc_pkg::CfgAddrW-1:0] idx,
                                 logic [rcc_pkg::CfgDataW-1:0] val);
      case (idx)
        rcc_pkg::CfgMidCommand:   mid_cmd = val;
        rcc_pkg::CfgDeadbandRoll: deadband[0] = val[rcc_pkg::DbW-1:0];
        rcc_pkg::CfgDeadbandPtch: deadband[1] = val[rcc_pkg::DbW-1:0];
        rcc_pkg::CfgDeadbandYaw:  deadband[2] = val[rcc_pkg::DbW-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return pending_outputs.size();
    endfunction

    // Works out the result that one accepted pulse causes and queues it.
    function void note_pulse(logic [rcc_pkg::ChanW-1:0] ch, logic [rcc_pkg::PulseW-1:0] pw);
      cond_result_t res;
      logic [rcc_pkg::PulseW-1:0] sample;
      int sum;
      int mean;
      int hv;
      int cmd;
      int db;
      int k;
      if (ch >= NumChannels) return;
      sample = (pw < rcc_pkg::PulseMin || pw > rcc_pkg::PulseMax) ? mid_cmd : pw;
      // The slot moves on first, then takes the new sample.
      slot[ch] = slot[ch] + 1'b1;
      window[ch][slot[ch]] = sample;
      sum = 0;
      for (k = 0; k < rcc_pkg::Window; k++) sum += int'(window[ch][k]);
      mean = (sum + 2) / 4;
      hv = int'(held_pulse[ch]);
      if (mean < hv - int'(rcc_pkg::HystLimit)) hv = mean + int'(rcc_pkg::HystStep);
      if (mean > hv + int'(rcc_pkg::HystLimit)) hv = mean - int'(rcc_pkg::HystStep);
      held_pulse[ch] = hv[rcc_pkg::PulseW-1:0];
      hv = int'(held_pulse[ch]);
      res.in_detent = 1'b0;
      cmd = 0;
      if (ch == rcc_pkg::ChRoll || ch == rcc_pkg::ChPitch || ch == rcc_pkg::ChYaw) begin
        db = int'(deadband[ch]);
        cmd = hv - int'(mid_cmd);
        if (cmd <= db && cmd >= -db) begin
          cmd = 0;
          res.in_detent = 1'b1;
        end else if (cmd > 0) begin
          cmd -= db;
        end else begin
          cmd += db;
        end
      end else if (ch == rcc_pkg::ChThrottle) begin
        cmd = hv - (int'(mid_cmd) - int'(rcc_pkg::ThrottleCentre));
        if (cmd > int'(rcc_pkg::CmdMax)) cmd = int'(rcc_pkg::CmdMax);
        if (cmd < int'(rcc_pkg::CmdMin)) cmd = int'(rcc_pkg::CmdMin);
      end
      res.out_channel = ch;
      res.filtered_pulse = held_pulse[ch];
      res.stick_command = cmd[rcc_pkg::CmdW-1:0];
      pending_outputs.push_back(res);
    endfunction

    function void compare_field(string label, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
        mismatches++;
      end
    endfunction

    function void check_output(logic [rcc_pkg::ChanW-1:0] ch, logic [rcc_pkg::PulseW-1:0] filt,
                               logic signed [rcc_pkg::CmdW-1:0] cmd, logic det);
      cond_result_t want;
      if (pending_outputs.size() == 0) begin
        $display("%0t: result with none expected, actual channel %0d pulse %0d", $time, ch,
                 filt);
        mismatches++;
        return;
      end
      want = pending_outputs.pop_front();
      compare_field("out_channel", want.out_channel, ch);
      compare_field("filtered_pulse", want.filtered_pulse, filt);
      compare_field("stick_command", want.stick_command, cmd);
      compare_field("in_detent", want.in_detent, det);
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [15:0]                  s_axis_tdata = '0;   // [11:0] pulse_width, [15:12] zero
  logic [2:0]                   s_axis_tuser = '0;   // [2:0] channel
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;  // [11:0] filtered_pulse, [24:12] stick_command
  logic [3:0]                   m_axis_tuser;  // [2:0] out_channel, [3] in_detent
  logic                         cfg_we_i = 1'b0;
  logic [rcc_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [rcc_pkg::CfgDataW-1:0] cfg_wdata_i = '0;

  channel_tracker tracker;
  bit          idle_on = 1'b1;
  int          sink_hold = 0;
  int unsigned quiet_cycles = 0;
  // Stick position per channel that the random pulses wander around.
  int          stick_pos [NumChannels];
  int          centre_now = int'(rcc_pkg::MidReset);

  rc_channel_conditioner_unit #(
    .CHANNELS(NumChannels)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: every handshake is checked against the oldest expectation, and tready
  // drops in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_output(m_axis_tuser[2:0], m_axis_tdata[11:0], m_axis_tdata[24:12],
                           m_axis_tuser[3]);
    end
    if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("[rc_channel_conditioner_unit] ERROR");
      $finish;
    end
  end

  // Presents one item, waits for its handshake and records it with the tracker. Valid stays
  // high afterwards so that back-to-back items stream without a gap.
  task automatic send_pulse(input logic [rcc_pkg::ChanW-1:0] ch,
                            input logic [rcc_pkg::PulseW-1:0] pw);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, pw};
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    tracker.note_pulse(ch, pw);
  endtask

  // Registers are written only while nothing is in flight.
  task automatic write_reg(input logic [rcc_pkg::CfgAddrW-1:0] idx,
                           input logic [rcc_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    tracker.write_register(idx, val);
    if (idx == rcc_pkg::CfgMidCommand) centre_now = int'(val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the input stream and waits until every expected result has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly a stick held near a position with a little jitter, now and then a jump (often to
  // the centre, where the deadband lives), plus out-of-range and fully random widths.
  function automatic logic [rcc_pkg::PulseW-1:0] pick_pulse(int ch, int junk_pct);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < junk_pct) begin
      if ($urandom_range(0, 1) == 0) v = $urandom_range(0, int'(rcc_pkg::PulseMin) - 1);
      else v = $urandom_range(int'(rcc_pkg::PulseMax) + 1, 4095);
      return v[rcc_pkg::PulseW-1:0];
    end
    if (r < junk_pct + 5) begin
      v = $urandom_range(0, 4095);
      return v[rcc_pkg::PulseW-1:0];
    end
    if (r < junk_pct + 20) begin
      if ($urandom_range(0, 1) == 0) begin
        stick_pos[ch] = centre_now + int'($urandom_range(0, 120)) - 60;
      end else begin
        stick_pos[ch] = $urandom_range(int'(rcc_pkg::PulseMin), int'(rcc_pkg::PulseMax));
      end
    end
    v = stick_pos[ch] + int'($urandom_range(0, 10)) - 5;
    if (v < int'(rcc_pkg::PulseMin)) v = int'(rcc_pkg::PulseMin);
    if (v > int'(rcc_pkg::PulseMax)) v = int'(rcc_pkg::PulseMax);
    return v[rcc_pkg::PulseW-1:0];
  endfunction

  initial begin
    int phase;
    int n;
    int ch;
    int junk_pct;
    logic [rcc_pkg::CfgDataW-1:0] mid_val;
    logic [rcc_pkg::CfgDataW-1:0] db_val [3];
    tracker = new();
    for (n = 0; n < NumChannels; n++) stick_pos[n] = int'(rcc_pkg::MidReset);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset configuration: the roll window fills from zero, a small
    // step stays inside the hysteresis band, and the pulse limits are probed on both sides.
    send_pulse(rcc_pkg::ChRoll, 12'd1500);
    send_pulse(rcc_pkg::ChRoll, 12'd1500);
    send_pulse(rcc_pkg::ChRoll, 12'd1500);
    send_pulse(rcc_pkg::ChRoll, 12'd1500);
    send_pulse(rcc_pkg::ChRoll, 12'd1502);
    send_pulse(rcc_pkg::ChRoll, 12'd749);
    send_pulse(rcc_pkg::ChRoll, 12'd2251);
    send_pulse(rcc_pkg::ChPitch, rcc_pkg::PulseMin);
    send_pulse(rcc_pkg::ChPitch, 12'd749);
    send_pulse(rcc_pkg::ChYaw, rcc_pkg::PulseMax);
    send_pulse(rcc_pkg::ChYaw, 12'd2251);
    send_pulse(rcc_pkg::ChYaw, 12'd4095);
    send_pulse(rcc_pkg::ChThrottle, 12'd0);
    send_pulse(rcc_pkg::ChThrottle, 12'd4095);
    send_pulse(rcc_pkg::ChThrottle, rcc_pkg::PulseMax);
    send_pulse(ChAuxFirst, 12'd1000);
    send_pulse(ChAuxFirst + 3'd1, 12'd4095);
    send_pulse(ChAuxFirst + 3'd2, 12'd0);
    send_pulse(ChAuxFirst + 3'd3, 12'd1700);
    drain_results();

    // Random phases, each under its own configuration. The phase with the centre at the
    // top of the range fills the windows with substitutes, and the next one drops the
    // centre to zero so that the throttle offset saturates.
    ch = 0;
    for (phase = 1; phase <= NumPhases; phase++) begin
      junk_pct = 10;
      case (phase)
        1: begin
          mid_val = 12'd1500; db_val[0] = 12'd25; db_val[1] = 12'd100; db_val[2] = 12'd0;
        end
        2: begin
          // The yaw value carries bits above the deadband width, which must be dropped.
          mid_val = rcc_pkg::PulseMin;
          db_val[0] = 12'd500; db_val[1] = 12'd0; db_val[2] = 12'hfff;
        end
        3: begin
          mid_val = rcc_pkg::PulseMax;
          db_val[0] = 12'd0; db_val[1] = 12'd500; db_val[2] = 12'd250;
        end
        4: begin
          mid_val = 12'hfff; db_val[0] = 12'd511; db_val[1] = 12'd1; db_val[2] = 12'd500;
          junk_pct = 60;
        end
        5: begin
          mid_val = 12'd0; db_val[0] = 12'd511; db_val[1] = 12'd511; db_val[2] = 12'd511;
          junk_pct = 30;
        end
        6: begin
          mid_val = rcc_pkg::CfgDataW'($urandom_range(int'(rcc_pkg::PulseMin),
                                                      int'(rcc_pkg::PulseMax)));
          db_val[0] = rcc_pkg::CfgDataW'($urandom_range(0, 500));
          db_val[1] = rcc_pkg::CfgDataW'($urandom_range(0, 500));
          db_val[2] = rcc_pkg::CfgDataW'($urandom_range(0, 500));
        end
        7: begin
          mid_val = rcc_pkg::CfgDataW'($urandom_range(0, 4095));
          db_val[0] = rcc_pkg::CfgDataW'($urandom_range(0, 4095));
          db_val[1] = rcc_pkg::CfgDataW'($urandom_range(0, 4095));
          db_val[2] = rcc_pkg::CfgDataW'($urandom_range(0, 4095));
          junk_pct = 25;
        end
        default: begin
          // Last part runs with no idling on either side.
          idle_on = 1'b0;
          mid_val = rcc_pkg::MidReset;
          db_val[0] = rcc_pkg::CfgDataW'($urandom_range(0, 60));
          db_val[1] = rcc_pkg::CfgDataW'($urandom_range(0, 60));
          db_val[2] = rcc_pkg::CfgDataW'($urandom_range(0, 60));
        end
      endcase
      write_reg(rcc_pkg::CfgMidCommand, mid_val);
      write_reg(rcc_pkg::CfgDeadbandRoll, db_val[0]);
      write_reg(rcc_pkg::CfgDeadbandPtch, db_val[1]);
      write_reg(rcc_pkg::CfgDeadbandYaw, db_val[2]);
      write_reg(rcc_pkg::CfgAddrW'($urandom_range(FirstUnusedIndex, 7)),
                rcc_pkg::CfgDataW'($urandom_range(0, 4095)));
      for (n = 0; n < ItemsPerPhase; n++) begin
        // Runs on one channel now and then, so its window turns over quickly.
        if ($urandom_range(0, 1) == 0) ch = $urandom_range(0, NumChannels - 1);
        send_pulse(ch[rcc_pkg::ChanW-1:0], pick_pulse(ch, junk_pct));
      end
      drain_results();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("[rc_channel_conditioner_unit] OK");
    end else begin
      $display("[rc_channel_conditioner_unit] ERROR");
    end
    $finish;
  end

endmodule
